// ===== hw/rtl/quaternion_to_euler_attitude_assert.svh =====
// Assertion macros for the attitude block RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef QUATERNION_TO_EULER_ATTITUDE_ASSERT_SVH
`define QUATERNION_TO_EULER_ATTITUDE_ASSERT_SVH
`ifndef ASSERT_OFF
`define QEA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QEA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QEA_ASSERT(label, clk, rst_n, prop, msg)
`define QEA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/qea_pkg.sv =====
// Shared constants and functions for the attitude block.
// No dependencies.
`timescale 1ns / 1ps
package qea_pkg;
  localparam int unsigned AngW = 40;
  localparam logic signed [AngW-1:0] AngQuarter = 40'sd2949120;

  // Reciprocal of 1250 scaled by 2^33, exact for every dividend below 2^22.
  localparam logic [22:0] DriveRecip = 23'd6871948;
  localparam int unsigned DriveShift = 33;
  // Smallest scaled stick value that maps to full drive.
  localparam logic signed [23:0] DriveFull = 24'sd2560000;

  // Arctangent of 2^-i in 1/32768 degree.
  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        0: v = 40'sd1474560;  1: v = 40'sd870484;  2: v = 40'sd459940;
        3: v = 40'sd233473;   4: v = 40'sd117189;  5: v = 40'sd58652;
        6: v = 40'sd29333;    7: v = 40'sd14667;   8: v = 40'sd7334;
        9: v = 40'sd3667;     10: v = 40'sd1833;   11: v = 40'sd917;
        12: v = 40'sd458;     13: v = 40'sd229;    14: v = 40'sd115;
        15: v = 40'sd57;      16: v = 40'sd29;     17: v = 40'sd14;
        18: v = 40'sd7;       19: v = 40'sd4;      20: v = 40'sd2;
        21: v = 40'sd1;       default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Stick to drive value: floor(stick*128/1250 + 1024), saturated to 0..2048.
  // Negative scaled values floor below zero and saturate, so only the range
  // between zero and full drive needs the reciprocal multiply.
  function automatic logic [11:0] stick_drive(input logic signed [14:0] stk);
    logic signed [23:0] t;
    logic [46:0] prod;
    begin
      t = 24'(stk) * 24'sd128 + 24'sd1280000;
      prod = 47'(t[21:0]) * 47'(DriveRecip);
      if (t < 0) return 12'd0;
      else if (t >= DriveFull) return 12'd2048;
      else return 12'(prod >> DriveShift);
    end
  endfunction
endpackage

// ===== hw/rtl/quaternion_to_euler_attitude.sv =====
// Top level of the attitude block: front product stages, back angle pipelines.
// Depends on qea_pkg, qea_front and qea_back.
`timescale 1ns / 1ps
// Usage:
//  The input stream carries one quaternion, one horizontal velocity and two
//  stick values per transfer; the output stream carries roll, pitch, yaw,
//  ground speed and two drive values per transfer. Each input yields exactly
//  one output, in order.
//  Between an item's input transfer and its out_tvalid lie two product and
//  sum stages, an argument register, a 31-stage square root (one result bit
//  per stage) for the pitch cosine, a CORDIC stage per step plus its
//  pre-rotation, and the result queue.
//  One transfer can be taken in every cycle while out_tready stays high.
//  When the receiver stalls, results collect in a four-entry queue; once it
//  is full the whole back pipeline holds, the two front stages fill and
//  in_tready drops until the receiver takes a result again.
//  Reset (rst_n low, synchronous) empties all stages and the queue.
module quaternion_to_euler_attitude #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUAT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // quat_w, quat_x, quat_y, quat_z, vel_x, vel_y, stick_yaw, stick_throttle
  input  logic [((4*QUAT_WIDTH+62)+7)/8*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // roll_angle, pitch_angle, yaw_angle, ground_speed, yaw_drive, throttle_drive
  output logic [87:0] out_tdata
);
  import qea_pkg::*;
  localparam int QW = QUAT_WIDTH;
  localparam int PW = 2*QW + 4;
  logic fv, fr;
  logic signed [PW-1:0] ry, rx, yy, yx, ps;
  logic [32:0] sp;
  logic [11:0] dy, dt;

  qea_front #(.QW(QW)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .w(in_tdata[QW-1:0]), .x(in_tdata[2*QW-1:QW]),
    .y(in_tdata[3*QW-1:2*QW]), .z(in_tdata[4*QW-1:3*QW]),
    .vx(in_tdata[4*QW+15:4*QW]), .vy(in_tdata[4*QW+31:4*QW+16]),
    .sy(in_tdata[4*QW+46:4*QW+32]), .st(in_tdata[4*QW+61:4*QW+47]),
    .o_valid(fv), .o_ready(fr),
    .ry_r(ry), .rx_r(rx), .yy_r(yy), .yx_r(yx), .ps_r(ps), .sp_r(sp),
    .dy_r(dy), .dt_r(dt)
  );

  qea_back #(.QW(QW), .STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .i_valid(fv), .i_ready(fr),
    .ry, .rx, .yy, .yx, .ps, .sp, .dy, .dt,
    .o_valid(out_tvalid), .o_ready(out_tready), .o_data(out_tdata)
  );
endmodule

// ===== hw/rtl/qea_front.sv =====
// Front: accepts items, forms quaternion products, vector sums, drive values.
// Depends on qea_pkg.
`timescale 1ns / 1ps
module qea_front #(
  parameter int QW = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [QW-1:0] w, x, y, z,
  input  logic signed [15:0] vx, vy,
  input  logic signed [14:0] sy, st,
  output logic o_valid,
  input  logic o_ready,
  output logic signed [2*QW+3:0] ry_r, rx_r, yy_r, yx_r, ps_r,
  output logic [32:0] sp_r,
  output logic [11:0] dy_r, dt_r
);
  import qea_pkg::*;
  localparam int PW = 2*QW + 4;
  logic v1_r, v2_r;
  logic signed [2*QW-1:0] pww_r, pxx_r, pyy_r, pzz_r, pwx_r, pyz_r, pwz_r, pxy_r;
  logic signed [2*QW-1:0] pwy_r, pxz_r;
  logic [31:0] pvx_r, pvy_r;
  logic [11:0] d1y_r, d1t_r;
  logic adv1, adv2;

  assign adv2 = !v2_r || o_ready;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;
  assign o_valid = v2_r;

  // Valid flags of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  // Stage one: products and stick drive values.
  always_ff @(posedge clk) begin
    if (adv1) begin
      pww_r <= w*w; pxx_r <= x*x; pyy_r <= y*y; pzz_r <= z*z;
      pwx_r <= w*x; pyz_r <= y*z; pwz_r <= w*z; pxy_r <= x*y;
      pwy_r <= w*y; pxz_r <= x*z;
      pvx_r <= 32'(vx*vx); pvy_r <= 32'(vy*vy);
      d1y_r <= stick_drive(sy); d1t_r <= stick_drive(st);
    end
  end

  // Stage two: sums.
  always_ff @(posedge clk) begin
    if (adv2) begin
      ry_r <= (PW'(pwx_r) + PW'(pyz_r)) <<< 1;
      rx_r <= PW'(pww_r) - PW'(pxx_r) - PW'(pyy_r) + PW'(pzz_r);
      yy_r <= (PW'(pwz_r) + PW'(pxy_r)) <<< 1;
      yx_r <= PW'(pww_r) + PW'(pxx_r) - PW'(pyy_r) - PW'(pzz_r);
      ps_r <= (PW'(pwy_r) - PW'(pxz_r)) <<< 1;
      sp_r <= {1'b0, pvx_r} + {1'b0, pvy_r};
      dy_r <= d1y_r; dt_r <= d1t_r;
    end
  end
endmodule

// ===== hw/rtl/qea_cordic.sv =====
// Pipelined CORDIC vectoring unit, one stage per step, angle in 1/128 degree.
// Depends on qea_pkg.
`timescale 1ns / 1ps
module qea_cordic #(
  parameter int W = 36,
  parameter int STEPS = 16,
  parameter int LIM = 23040
) (
  input  logic clk,
  input  logic en,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] x_in,
  output logic signed [15:0] ang
);
  import qea_pkg::*;
  localparam int XW = W + 3;
  logic signed [XW-1:0] x_r [STEPS+1];
  logic signed [XW-1:0] y_r [STEPS+1];
  logic signed [AngW-1:0] z_r [STEPS+1];
  logic zero_r [STEPS+1];
  logic signed [AngW-1:0] zr;

  // Pre-rotation into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r[0] <= XW'(y_in); y_r[0] <= -XW'(x_in); z_r[0] <= AngQuarter;
        end else begin
          x_r[0] <= -XW'(y_in); y_r[0] <= XW'(x_in); z_r[0] <= -AngQuarter;
        end
      end else begin
        x_r[0] <= XW'(x_in); y_r[0] <= XW'(y_in); z_r[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  // Rounding, saturation, and zero output for a zero input vector.
  always_comb begin
    zr = (z_r[STEPS] + AngW'(128)) >>> 8;
    if (zero_r[STEPS]) ang = '0;
    else if (zr > AngW'(LIM)) ang = 16'(LIM);
    else if (zr < -AngW'(LIM)) ang = -16'(LIM);
    else ang = 16'(zr);
  end
endmodule

// ===== hw/rtl/qea_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// No dependencies.
`timescale 1ns / 1ps
module qea_isqrt #(
  parameter int NW = 62
) (
  input  logic clk,
  input  logic en,
  input  logic [NW-1:0] n_in,
  output logic [NW/2-1:0] root,
  output logic [NW-1:0] rem
);
  localparam int RW = NW / 2;
  logic [NW:0] rm_r [RW+1];
  logic [RW-1:0] q_r [RW+1];
  logic [NW:0] trial [RW];

  always_comb begin
    rm_r[0] = {1'b0, n_in};
    q_r[0] = '0;
  end

  // Restoring digit recurrence, registered each bit.
  for (genvar i = 0; i < RW; i++) begin : g_bit
    localparam int B = RW - 1 - i;
    always_comb trial[i] = ((NW+1)'(q_r[i]) << (B+1)) + ((NW+1)'(1) << (2*B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rm_r[i] >= trial[i]) begin
          rm_r[i+1] <= rm_r[i] - trial[i];
          q_r[i+1] <= q_r[i] | (RW'(1) << B);
        end else begin
          rm_r[i+1] <= rm_r[i];
          q_r[i+1] <= q_r[i];
        end
      end
    end
  end

  assign root = q_r[RW];
  assign rem = rm_r[RW][NW-1:0];
endmodule

// ===== hw/rtl/qea_back.sv =====
// Back part: pitch argument, square roots, three CORDIC pipelines, result queue.
// Depends on qea_pkg, qea_cordic, qea_isqrt and the assertion macro header.
`timescale 1ns / 1ps
module qea_back #(
  parameter int QW = 16,
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic i_valid,
  output logic i_ready,
  input  logic signed [2*QW+3:0] ry, rx, yy, yx, ps,
  input  logic [32:0] sp,
  input  logic [11:0] dy, dt,
  output logic o_valid,
  input  logic o_ready,
  output logic [87:0] o_data
);
  import qea_pkg::*;
  `include "quaternion_to_euler_attitude_assert.svh"
  localparam int PW = 2*QW + 4;
  localparam int TF = 2*(QW-2);
  localparam int DEP = 1 + 31 + STEPS + 1;
  localparam int QD = 4;
  localparam int CW = $clog2(QD+1);

  logic en;
  logic [DEP-1:0] vld_r;
  logic signed [PW-1:0] one;
  logic signed [PW-1:0] sc;
  logic signed [31:0] s30, s30_r;
  logic [61:0] arg, sq;
  logic [30:0] croot;
  logic [61:0] crem;
  logic [16:0] groot;
  logic [33:0] grem;
  logic signed [31:0] sdl_r [31];
  logic [16:0] gr_r;
  logic [11:0] dyd_r [DEP];
  logic [11:0] dtd_r [DEP];
  logic signed [PW-1:0] ryd_r [31+1], rxd_r [31+1], yyd_r [31+1], yxd_r [31+1];
  logic [15:0] gsd_r [STEPS+14];
  logic [33:0] sp_d_r;
  logic signed [15:0] roll, yaw, pang;
  logic [87:0] res;
  logic [87:0] q_r [QD];
  logic [CW-1:0] cnt_r;
  logic [$clog2(QD)-1:0] wp_r, rp_r;
  logic push, pop;

  // The whole back pipeline holds while the result queue is full.
  assign en = cnt_r != CW'(QD);
  assign i_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEP-2:0], i_valid};
  end

  // Pitch argument saturation and rescale to Q30.
  always_comb begin
    one = PW'(1) <<< TF;
    if (ps > one) sc = one;
    else if (ps < -one) sc = -one;
    else sc = ps;
    if (TF > 30) s30 = 32'(sc >>> (TF > 30 ? TF - 30 : 0));
    else s30 = 32'(sc <<< (TF > 30 ? 0 : 30 - TF));
  end

  always_ff @(posedge clk) begin
    if (en) s30_r <= s30;
  end
  assign sq = 62'(64'(s30_r) * 64'(s30_r));
  assign arg = (62'(1) << 60) - sq;

  qea_isqrt #(.NW(62)) u_csqrt (.clk, .en, .n_in(arg), .root(croot), .rem(crem));

  // Delay lines aligning operands with the root and CORDIC pipelines.
  always_ff @(posedge clk) begin
    if (en) begin
      sdl_r[0] <= s30_r;
      for (int k = 1; k < 31; k++) sdl_r[k] <= sdl_r[k-1];
      ryd_r[0] <= ry; rxd_r[0] <= rx; yyd_r[0] <= yy; yxd_r[0] <= yx;
      for (int k = 1; k < 32; k++) begin
        ryd_r[k] <= ryd_r[k-1]; rxd_r[k] <= rxd_r[k-1];
        yyd_r[k] <= yyd_r[k-1]; yxd_r[k] <= yxd_r[k-1];
      end
      dyd_r[0] <= dy; dtd_r[0] <= dt;
      for (int k = 1; k < DEP; k++) begin
        dyd_r[k] <= dyd_r[k-1]; dtd_r[k] <= dtd_r[k-1];
      end
      gr_r <= (33'(grem) > 33'(groot)) ? groot + 17'd1 : groot;
      gsd_r[0] <= 16'(gr_r);
      for (int k = 1; k < STEPS+14; k++) gsd_r[k] <= gsd_r[k-1];
    end
  end

  // Ground speed root; its shorter pipeline is padded by the delay line above.
  always_ff @(posedge clk) begin
    if (en) sp_d_r <= {1'b0, sp};
  end
  qea_isqrt #(.NW(34)) u_gsqrt (.clk, .en, .n_in(sp_d_r), .root(groot), .rem(grem));

  qea_cordic #(.W(PW), .STEPS(STEPS), .LIM(23040)) u_roll
    (.clk, .en, .y_in(ryd_r[31]), .x_in(rxd_r[31]), .ang(roll));
  qea_cordic #(.W(PW), .STEPS(STEPS), .LIM(23040)) u_yaw
    (.clk, .en, .y_in(yyd_r[31]), .x_in(yxd_r[31]), .ang(yaw));
  qea_cordic #(.W(33), .STEPS(STEPS), .LIM(11520)) u_pitch
    (.clk, .en, .y_in(33'(sdl_r[30])), .x_in({2'b00, croot}), .ang(pang));

  assign res = {1'b0, dtd_r[DEP-1], dyd_r[DEP-1], gsd_r[STEPS+13], yaw, pang[14:0],
                roll};

  // Result queue.
  assign push = vld_r[DEP-1] && en;
  assign pop = o_valid && o_ready;
  assign o_valid = cnt_r != '0;
  assign o_data = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= res;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  `QEA_ASSERT(a_no_overflow, clk, rst_n, !(push && !pop && cnt_r == CW'(QD)), "queue overflow")
  `QEA_ASSERT(a_no_underflow, clk, rst_n, !(pop && cnt_r == '0), "queue underflow")
  `QEA_ASSERT(a_count_range, clk, rst_n, cnt_r <= CW'(QD), "queue count out of range")
endmodule

// ===== tb/quaternion_to_euler_attitude_test.sv =====
// Self-checking testbench for quaternion_to_euler_attitude: drives quaternion,
// velocity and stick transfers and checks every result against a local predictor.
// Depends on the RTL top level only.
`timescale 1ns / 1ps
module quaternion_to_euler_attitude_test;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [15:0] vx, vy;
    logic signed [14:0] stk_yaw, stk_thr;
  } attitude_sample_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic [15:0] speed;
    logic [11:0] yaw_drv, thr_drv;
  } attitude_result_t;

  localparam int NumRandom = 600;
  localparam int LongStall = 400;
  localparam longint QuarterTurn = 2949120;
  localparam longint ArcTab[16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
    29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [87:0] out_tdata;

  attitude_sample_t pending_samples[$];
  attitude_result_t expected_angles[$];
  int errors;
  int n_accepted;
  int n_checked;
  int gap_left;
  int burst_left;
  int cycle_cnt;
  int stall_left;
  bit stall_done;
  bit stim_done;

  quaternion_to_euler_attitude dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in 1/128 degree, saturated to +-lim.
  function automatic longint cordic_atan2(input longint y, input longint x,
                                          input longint lim);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QuarterTurn;
      end else begin
        x = -y; y = t; z = -QuarterTurn;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += ArcTab[i];
      end else begin
        x -= dy; y += dx; z -= ArcTab[i];
      end
    end
    z = (z + 128) >>> 8;
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  function automatic logic [11:0] thruster_cmd(input logic signed [14:0] stk);
    longint t;
    longint d;
    t = longint'(stk) * 128 + 1280000;
    d = (t >= 0) ? t / 1250 : -((-t + 1249) / 1250);
    if (d < 0) d = 0;
    if (d > 2048) d = 2048;
    return 12'(d);
  endfunction

  function automatic attitude_result_t predict_attitude(input attitude_sample_t a);
    attitude_result_t r;
    longint w, x, y, z, vx, vy, s;
    longint unsigned c, n, q;
    w = a.qw; x = a.qx; y = a.qy; z = a.qz;
    vx = a.vx; vy = a.vy;
    r.roll = 16'(cordic_atan2(2 * (w * x + y * z), w * w - x * x - y * y + z * z, 23040));
    r.yaw = 16'(cordic_atan2(2 * (w * z + x * y), w * w + x * x - y * y - z * z, 23040));
    // asin argument saturated to +-1.0 in Q28, then moved to Q30.
    s = 2 * (w * y - x * z);
    if (s > (64'sd1 <<< 28)) s = 64'sd1 <<< 28;
    if (s < -(64'sd1 <<< 28)) s = -(64'sd1 <<< 28);
    s = s <<< 2;
    c = int_sqrt((64'd1 << 60) - 64'(s * s));
    r.pitch = 15'(cordic_atan2(s, longint'(c), 11520));
    n = 64'(vx * vx) + 64'(vy * vy);
    q = int_sqrt(n);
    if (n - q * q > q) q++;
    r.speed = 16'(q);
    r.yaw_drv = thruster_cmd(a.stk_yaw);
    r.thr_drv = thruster_cmd(a.stk_thr);
    return r;
  endfunction

  function automatic attitude_sample_t unpack_sample(input logic [127:0] d);
    attitude_sample_t a;
    a.qw = d[15:0]; a.qx = d[31:16]; a.qy = d[47:32]; a.qz = d[63:48];
    a.vx = d[79:64]; a.vy = d[95:80];
    a.stk_yaw = d[110:96]; a.stk_thr = d[125:111];
    return a;
  endfunction

  task automatic add_sample(input int qw, qx, qy, qz, vx, vy, sy, st);
    attitude_sample_t a;
    a.qw = 16'(qw); a.qx = 16'(qx); a.qy = 16'(qy); a.qz = 16'(qz);
    a.vx = 16'(vx); a.vy = 16'(vy);
    a.stk_yaw = 15'(sy); a.stk_thr = 15'(st);
    pending_samples.push_back(a);
  endtask

  function automatic int rand_signed(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() > 0) begin
        attitude_sample_t a;
        a = pending_samples.pop_front();
        in_tdata <= {2'b00, a.stk_thr, a.stk_yaw, a.vy, a.vx, a.qz, a.qy, a.qx, a.qw};
        nxt_valid = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Receiver: random stalls, steady-ready stretches, one long hold-off to fill up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      cycle_cnt <= 0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!stall_done && n_accepted >= 200) begin
        stall_done <= 1'b1;
        stall_left <= LongStall;
        out_tready <= 1'b0;
      end else if ((cycle_cnt / 256) % 3 == 1) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(3, 0) != 0);
      end
    end
  end

  // Input monitor and result checker.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_angles.push_back(predict_attitude(unpack_sample(in_tdata)));
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      attitude_result_t e;
      attitude_result_t g;
      g.roll = out_tdata[15:0]; g.pitch = out_tdata[30:16]; g.yaw = out_tdata[46:31];
      g.speed = out_tdata[62:47]; g.yaw_drv = out_tdata[74:63];
      g.thr_drv = out_tdata[86:75];
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, out_tdata);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (g.roll !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, g.roll);
          errors++;
        end
        if (g.pitch !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, g.pitch);
          errors++;
        end
        if (g.yaw !== e.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, g.yaw);
          errors++;
        end
        if (g.speed !== e.speed) begin
          $display("%0t: speed expected %0d actual %0d", $time, e.speed, g.speed);
          errors++;
        end
        if (g.yaw_drv !== e.yaw_drv) begin
          $display("%0t: yaw drive expected %0d actual %0d", $time, e.yaw_drv, g.yaw_drv);
          errors++;
        end
        if (g.thr_drv !== e.thr_drv) begin
          $display("%0t: throttle drive expected %0d actual %0d", $time, e.thr_drv,
                   g.thr_drv);
          errors++;
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int wait_cycles;
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    // Directed: zero vector, identity, gimbal lock both ways, unnormalized,
    // negative-x rotation, field extremes and stick saturation.
    add_sample(0, 0, 0, 0, 0, 0, 0, 0);
    add_sample(16384, 0, 0, 0, 256, 0, 10000, -10000);
    add_sample(11585, 0, 11585, 0, 0, 256, -1, 1);
    add_sample(11585, 0, -11585, 0, -256, 0, 16383, -16384);
    add_sample(16384, 0, 16384, 0, 32767, 32767, -16384, 16383);
    add_sample(16384, 0, -16384, 0, -32768, -32768, 0, 0);
    add_sample(16384, 16384, 16384, 16384, -32768, 0, 9999, -9999);
    add_sample(0, 16384, 0, 0, 0, -32768, 1, -1);
    add_sample(0, 0, 0, 16384, 100, -100, 5000, -5000);
    add_sample(0, 0, 16384, 0, 3, 4, 12, -13);
    add_sample(-16384, -16384, -16384, -16384, 32767, -32768, -12500, 12500);
    add_sample(-16384, 16384, -16384, 16384, 1, 1, 4000, 8000);
    add_sample(8192, -8192, 8192, -8192, 0, 1, -8000, -4000);
    add_sample(1, 0, 0, 0, 1, 0, 16383, 16383);
    add_sample(0, -1, 0, 0, 0, 0, -16384, -16384);
    add_sample(-16384, 0, 0, 0, 181, 181, 0, 0);
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(3, 0) == 0) begin
        add_sample(rand_signed(-16384, 16384), rand_signed(-16384, 16384),
                   rand_signed(-16384, 16384), rand_signed(-16384, 16384),
                   rand_signed(-32768, 32767), rand_signed(-32768, 32767),
                   rand_signed(-16384, 16383), rand_signed(-16384, 16383));
      end else begin
        // Roughly unit-length quaternions: halve the components until small enough.
        int w, x, y, z;
        w = rand_signed(-16384, 16384); x = rand_signed(-16384, 16384);
        y = rand_signed(-16384, 16384); z = rand_signed(-16384, 16384);
        while (longint'(w) * w + longint'(x) * x + longint'(y) * y + longint'(z) * z
               > 64'sd268435456) begin
          w = w / 2; x = x / 2; y = y / 2; z = z / 2;
        end
        add_sample(w, x, y, z, rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                   rand_signed(-10000, 10000), rand_signed(-10000, 10000));
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_samples.size() == 0);
    @(posedge clk);
    while (in_tvalid && !in_tready) @(posedge clk);
    @(posedge clk);
    wait_cycles = 0;
    while (expected_angles.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (expected_angles.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_angles.size());
      errors++;
    end
    $display("Covered %0d attitude transfers (%0d results checked), including gimbal",
             n_accepted, n_checked);
    $display("lock, zero and unnormalized quaternions, speed and stick extremes.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qea_pkg.sv
hw/rtl/qea_front.sv
hw/rtl/qea_cordic.sv
hw/rtl/qea_isqrt.sv
hw/rtl/qea_back.sv
hw/rtl/quaternion_to_euler_attitude.sv
tb/quaternion_to_euler_attitude_test.sv
